### hdl/gpioreg_pkg.sv
// package with shared constants and types of the gpio register block
`timescale 1ns / 1ps
`default_nettype none

package gpioreg_pkg;

  // pin fields on the bus side are fixed at this width
  localparam int PIN_FIELD_W      = 54;
  localparam int GPIOREG_PIN_COUNT = 54;

  localparam int DATA_W        = 32;
  localparam int ADDR_W        = 4;
  localparam int MODE_W        = 3;
  localparam int FSEL_WORDS    = 6;
  localparam int PINS_PER_FSEL = 10;
  localparam int FSEL_WORD_W   = 3;
  localparam int LEVEL_W       = 64;

  localparam logic [MODE_W-1:0] MODE_OUTPUT = 3'd1;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [ADDR_W-1:0] ADDR_FSEL0 = 4'd0;
  localparam logic [ADDR_W-1:0] ADDR_FSEL1 = 4'd1;
  localparam logic [ADDR_W-1:0] ADDR_FSEL2 = 4'd2;
  localparam logic [ADDR_W-1:0] ADDR_FSEL3 = 4'd3;
  localparam logic [ADDR_W-1:0] ADDR_FSEL4 = 4'd4;
  localparam logic [ADDR_W-1:0] ADDR_FSEL5 = 4'd5;
  localparam logic [ADDR_W-1:0] ADDR_SET0  = 4'd7;
  localparam logic [ADDR_W-1:0] ADDR_SET1  = 4'd8;
  localparam logic [ADDR_W-1:0] ADDR_CLR0  = 4'd10;
  localparam logic [ADDR_W-1:0] ADDR_CLR1  = 4'd11;
  localparam logic [ADDR_W-1:0] ADDR_LEV0  = 4'd13;
  localparam logic [ADDR_W-1:0] ADDR_LEV1  = 4'd14;

  // write command from the decoder to the pin state
  typedef struct packed {
    logic                   fsel_we;
    logic [FSEL_WORD_W-1:0] fsel_word;
    logic                   set_we;
    logic                   clr_we;
    logic                   hi_half;
    logic [DATA_W-1:0]      data;
  } gpioreg_wr_t;

endpackage

`default_nettype wire

### hdl/gpioreg_if.sv
// valid/ready channel interfaces for access items and result items
`timescale 1ns / 1ps
`default_nettype none

interface gpioreg_in_if import gpioreg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   req_type;
  logic [ADDR_W-1:0]      word_address;
  logic [DATA_W-1:0]      write_data;
  logic [PIN_FIELD_W-1:0] pin_levels;

  modport source (output valid, output req_type, output word_address,
                  output write_data, output pin_levels, input ready);
  modport sink (input valid, input req_type, input word_address,
                input write_data, input pin_levels, output ready);
endinterface

interface gpioreg_out_if import gpioreg_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [DATA_W-1:0]      read_data;
  logic [PIN_FIELD_W-1:0] pin_drive;
  logic [PIN_FIELD_W-1:0] pin_drive_enable;

  modport source (output valid, output read_data, output pin_drive,
                  output pin_drive_enable, input ready);
  modport sink (input valid, input read_data, input pin_drive,
                input pin_drive_enable, output ready);
endinterface

`default_nettype wire

### hdl/gpioreg_pin_state.sv
// pin mode registers and output latch with write command handling
`timescale 1ns / 1ps
`default_nettype none

module gpioreg_pin_state import gpioreg_pkg::*; #(
  parameter int PIN_COUNT = GPIOREG_PIN_COUNT
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          wr_en,
  input  wire gpioreg_wr_t                   wr,
  output logic        [PIN_COUNT*MODE_W-1:0] fsel_flat,
  output logic        [PIN_COUNT-1:0]        latch,
  output logic        [PIN_COUNT-1:0]        drive_en
);

  logic [PIN_COUNT-1:0] latch_r;
  logic [PIN_COUNT-1:0] latch_nxt;
  logic [LEVEL_W-1:0]   bits64;
  logic [PIN_COUNT-1:0] bits;

  // per-pin mode registers; pins past the last select word stay inputs
  for (genvar p = 0; p < PIN_COUNT; p++) begin : g_pin
    if (p / PINS_PER_FSEL < FSEL_WORDS) begin : g_mode
      localparam int W = p / PINS_PER_FSEL;
      localparam int S = p % PINS_PER_FSEL;
      logic [MODE_W-1:0] mode_r;
      logic [MODE_W-1:0] mode_nxt;

      always_comb begin
        mode_nxt = mode_r;
        if (wr_en && wr.fsel_we && (wr.fsel_word == FSEL_WORD_W'(W))) begin
          mode_nxt = wr.data[MODE_W*S +: MODE_W];
        end
      end

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          mode_r <= '0;
        end else begin
          mode_r <= mode_nxt;
        end
      end

      assign fsel_flat[MODE_W*p +: MODE_W] = mode_r;
    end else begin : g_fixed
      assign fsel_flat[MODE_W*p +: MODE_W] = '0;
    end
    assign drive_en[p] = (fsel_flat[MODE_W*p +: MODE_W] == MODE_OUTPUT);
  end

  // set/clear mask placed on the selected 32-pin half
  always_comb begin
    bits64 = wr.hi_half ? {wr.data, {DATA_W{1'b0}}}
                        : {{(LEVEL_W-DATA_W){1'b0}}, wr.data};
    bits   = bits64[PIN_COUNT-1:0];
    latch_nxt = latch_r;
    if (wr_en && wr.set_we) begin
      latch_nxt = latch_r | bits;
    end else if (wr_en && wr.clr_we) begin
      latch_nxt = latch_r & ~bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= '0;
    end else begin
      latch_r <= latch_nxt;
    end
  end

  assign latch = latch_r;

endmodule

`default_nettype wire

### hdl/gpio_register_block_core.sv
// top level of the gpio register block: access decode, pipeline and result register
//
// usage
//   in_ch  : one register access per item (req_type, word_address, write_data,
//            pin_levels). accepted when valid and ready are both high.
//   out_ch : one result item per access: read_data (zero on writes and on
//            write-only or unused words), pin_drive and pin_drive_enable as they
//            stand after the access.
// result: an accepted item is held in the input register, then moves to the
//   result register, where its result shows valid until it is taken.
// throughput: one item per cycle while out_ch.ready stays high; the input
//   register and the result register each hold one item, and the pin state
//   changes only when the result register loads.
// stall: when out_ch.ready is low a full result register holds; the input
//   register still takes one more item, then in_ch.ready drops until the
//   result is taken.
// reset: rst_n is synchronous, active low. all pins become inputs, the output
//   latch clears and both registers empty; no clearing pass is needed.
// pin_drive and pin_drive_enable come straight from the state registers,
//   which cannot move while a result waits.
`timescale 1ns / 1ps
`default_nettype none

module gpio_register_block_core import gpioreg_pkg::*; #(
  parameter int PIN_COUNT = GPIOREG_PIN_COUNT
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  gpioreg_in_if.sink   in_ch,
  gpioreg_out_if.source out_ch
);

  // input register stage
  logic                   s1_valid_r;
  logic                   s1_valid_nxt;
  logic                   s1_req_type_r;
  logic [ADDR_W-1:0]      s1_addr_r;
  logic [DATA_W-1:0]      s1_data_r;
  logic [PIN_FIELD_W-1:0] s1_levels_r;

  // result register stage
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic [DATA_W-1:0] read_data_r;
  logic [DATA_W-1:0] read_data_nxt;

  logic advance;
  logic in_fire;

  gpioreg_wr_t                  wr;
  logic [PIN_COUNT*MODE_W-1:0]  fsel_flat;
  logic [PIN_COUNT-1:0]         latch;
  logic [PIN_COUNT-1:0]         drive_en;

  logic [DATA_W-1:0]      fsel_word_data [FSEL_WORDS];
  logic [LEVEL_W-1:0]     ext64;
  logic [PIN_COUNT-1:0]   ext;
  logic [PIN_COUNT-1:0]   level;
  logic [LEVEL_W-1:0]     level64;
  logic [LEVEL_W-1:0]     latch64;
  logic [LEVEL_W-1:0]     drive_en64;

  // handshake: stage 1 moves on when the result register is free or drains
  assign advance     = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req_type_r <= in_ch.req_type;
      s1_addr_r     <= in_ch.word_address;
      s1_data_r     <= in_ch.write_data;
      s1_levels_r   <= in_ch.pin_levels;
    end
    if (advance) begin
      read_data_r <= read_data_nxt;
    end
  end

  // write decode; only applied when the item advances
  always_comb begin
    wr           = '0;
    wr.data      = s1_data_r;
    wr.fsel_word = s1_addr_r[FSEL_WORD_W-1:0];
    if (s1_req_type_r == REQ_WRITE) begin
      unique case (s1_addr_r)
        ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2,
        ADDR_FSEL3, ADDR_FSEL4, ADDR_FSEL5: wr.fsel_we = 1'b1;
        ADDR_SET0: wr.set_we = 1'b1;
        ADDR_SET1: begin
          wr.set_we  = 1'b1;
          wr.hi_half = 1'b1;
        end
        ADDR_CLR0: wr.clr_we = 1'b1;
        ADDR_CLR1: begin
          wr.clr_we  = 1'b1;
          wr.hi_half = 1'b1;
        end
        default: ;
      endcase
    end
  end

  gpioreg_pin_state #(
    .PIN_COUNT (PIN_COUNT)
  ) u_pin_state (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (advance),
    .wr        (wr),
    .fsel_flat (fsel_flat),
    .latch     (latch),
    .drive_en  (drive_en)
  );

  // function-select words as read back; missing pins and bits 31:30 read zero
  for (genvar w = 0; w < FSEL_WORDS; w++) begin : g_fsel_word
    for (genvar s = 0; s < PINS_PER_FSEL; s++) begin : g_slot
      if (w * PINS_PER_FSEL + s < PIN_COUNT) begin : g_real
        assign fsel_word_data[w][MODE_W*s +: MODE_W] =
            fsel_flat[MODE_W*(w*PINS_PER_FSEL+s) +: MODE_W];
      end else begin : g_missing
        assign fsel_word_data[w][MODE_W*s +: MODE_W] = '0;
      end
    end
    assign fsel_word_data[w][DATA_W-1:MODE_W*PINS_PER_FSEL] = '0;
  end

  // level: driven latch for output pins, external level for the rest
  always_comb begin
    ext64   = {{(LEVEL_W-PIN_FIELD_W){1'b0}}, s1_levels_r};
    ext     = ext64[PIN_COUNT-1:0];
    level   = (latch & drive_en) | (ext & ~drive_en);
    level64 = LEVEL_W'(level);
  end

  // read data; reads never change state, so the current state is the answer
  always_comb begin
    read_data_nxt = '0;
    if (s1_req_type_r == REQ_READ) begin
      unique case (s1_addr_r)
        ADDR_FSEL0, ADDR_FSEL1, ADDR_FSEL2,
        ADDR_FSEL3, ADDR_FSEL4, ADDR_FSEL5:
          read_data_nxt = fsel_word_data[s1_addr_r[FSEL_WORD_W-1:0]];
        ADDR_LEV0: read_data_nxt = level64[DATA_W-1:0];
        ADDR_LEV1: read_data_nxt = level64[LEVEL_W-1:DATA_W];
        default:   read_data_nxt = '0;
      endcase
    end
  end

  // pin outputs track the state, which only moves when a result loads
  assign latch64    = LEVEL_W'(latch);
  assign drive_en64 = LEVEL_W'(drive_en);

  assign out_ch.valid            = out_valid_r;
  assign out_ch.read_data        = read_data_r;
  assign out_ch.pin_drive        = latch64[PIN_FIELD_W-1:0];
  assign out_ch.pin_drive_enable = drive_en64[PIN_FIELD_W-1:0];

endmodule

`default_nettype wire
